// ===== rtl/sme_pkg.sv =====
package sme_pkg;

   // Matrix geometry
   localparam int MAX_DIM = 16;
   localparam int IDX_W   = $clog2(MAX_DIM);
   localparam int DIM_W   = $clog2(MAX_DIM + 1);
   localparam int ADDR_W  = 2 * IDX_W;
   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int DATA_W  = 32;

   // Register file
   localparam int CSR_AW  = 5;
   localparam int CSR_DW  = 32;
   localparam logic [2:0] REG_OP_MODE = 3'd0;
   localparam logic [2:0] REG_A_ROWS  = 3'd1;
   localparam logic [2:0] REG_A_COLS  = 3'd2;
   localparam logic [2:0] REG_B_ROWS  = 3'd3;
   localparam logic [2:0] REG_B_COLS  = 3'd4;

   // Operation codes held in op_mode
   localparam logic [1:0] MODE_ADD       = 2'd0;
   localparam logic [1:0] MODE_MULTIPLY  = 2'd1;
   localparam logic [1:0] MODE_TRANSPOSE = 2'd2;

   typedef enum logic [1:0] {
      CMD_LOAD_A  = 2'd0,
      CMD_LOAD_B  = 2'd1,
      CMD_COMPUTE = 2'd2,
      CMD_READ    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_DIM  = 2'd1,
      STATUS_ADDR = 2'd2,
      STATUS_NONE = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_READ  = 4'b1000
   } state_type;

   // Tag that travels with each element through the compute pipeline
   typedef struct packed {
      logic              first;
      logic              last;
      logic [ADDR_W-1:0] waddr;
   } tag_type;

endpackage

// ===== rtl/sme_ram.sv =====
module sme_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/small_matrix_engine.sv =====
// Small integer matrix engine.
// The req channel carries one command per transfer: load an element of A,
// load an element of B, compute, or read one result element. Every command
// returns exactly one transfer on the rsp channel with the read value (zero
// for anything but a good read), a status code and the current result shape.
// op_mode and the four dimension registers sit on the csr port; write them
// only while no command is in flight.
// Order of events, from the req transfer to the rsp transfer being offered:
//   load, failed read, rejected compute : response registered in the next cycle
//   read of a result element            : result memory read, ST_READ, then the rsp register
//   compute                              : ST_RUN issues N element steps, N =
//     a_rows*b_cols*a_cols for multiply, a_rows*a_cols for add or
//     transpose; ST_DRAIN then waits for the pipe to empty. One multiply/add unit does one
//     step per cycle behind a two-stage pipe fed by the operand memories.
// The block takes one command at a time: req_tready is high only when the
// sequencer is idle and the rsp register is empty or being emptied. A stalled
// rsp channel holds the response and keeps req_tready low.
// Reset restores the register defaults (multiply, all dimensions 1) and drops
// any result; the element memories are not cleared and hold no defined value
// until loaded.
module small_matrix_engine (
   input  logic                        clock,
   input  logic                        reset,
   // req_tdata: row_index [3:0], col_index [7:4], element_value [39:8]
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [39:0]                 req_tdata,
   // req_tuser: command [1:0]
   input  logic [1:0]                  req_tuser,
   // rsp_tdata: result_value [31:0], result_rows [36:32], result_cols [41:37]
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [47:0]                 rsp_tdata,
   // rsp_tuser: status [1:0]
   output logic [1:0]                  rsp_tuser,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [sme_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [sme_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [sme_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);

   import sme_pkg::*;

   // Configuration registers
   logic [1:0]       op_mode_ff, op_mode_in;
   logic [DIM_W-1:0] a_rows_ff, a_rows_in;
   logic [DIM_W-1:0] a_cols_ff, a_cols_in;
   logic [DIM_W-1:0] b_rows_ff, b_rows_in;
   logic [DIM_W-1:0] b_cols_ff, b_cols_in;

   // Sequencer and result bookkeeping
   state_type        state_ff, state_in;
   logic             result_valid_ff, result_valid_in;
   logic [DIM_W-1:0] result_rows_ff, result_rows_in;
   logic [DIM_W-1:0] result_cols_ff, result_cols_in;

   // Compute loop
   logic [1:0]       mode_ff, mode_in;
   logic [DIM_W-1:0] lim_i_ff, lim_i_in;
   logic [DIM_W-1:0] lim_j_ff, lim_j_in;
   logic [DIM_W-1:0] lim_k_ff, lim_k_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] k_ff, k_in;

   // Pipeline
   logic             s1_valid_ff, s1_valid_in;
   tag_type          s1_tag_ff, s1_tag_in;
   logic             s2_valid_ff;
   tag_type          s2_tag_ff;
   logic [DATA_W-1:0] term_ff, term_in;
   logic [DATA_W-1:0] acc_ff, acc_in;

   // Response register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [DIM_W-1:0] rsp_rows_ff, rsp_rows_in;
   logic [DIM_W-1:0] rsp_cols_ff, rsp_cols_in;

   // Request fields
   cmd_type          req_cmd;
   logic [IDX_W-1:0] req_row;
   logic [IDX_W-1:0] req_col;
   logic [DATA_W-1:0] req_value;
   logic             req_xfer;

   // Memory ports
   logic              a_wr_en, b_wr_en, res_wr_en;
   logic [ADDR_W-1:0] ld_addr;
   logic [ADDR_W-1:0] a_rd_addr, b_rd_addr, res_rd_addr;
   logic [DATA_W-1:0] a_rd_data, b_rd_data, res_rd_data;
   logic [DATA_W-1:0] acc_sum;
   logic [DATA_W-1:0] mul_low;

   // Register write decode
   logic             csr_wr;
   logic [2:0]       csr_index;

   assign req_cmd   = cmd_type'(req_tuser[1:0]);
   assign req_row   = req_tdata[IDX_W-1:0];
   assign req_col   = req_tdata[2*IDX_W-1:IDX_W];
   assign req_value = req_tdata[2*IDX_W+DATA_W-1:2*IDX_W];
   assign ld_addr   = {req_row, req_col};

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_xfer   = req_tvalid && req_tready;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   // Register writes
   always_comb begin
      op_mode_in = op_mode_ff;
      a_rows_in  = a_rows_ff;
      a_cols_in  = a_cols_ff;
      b_rows_in  = b_rows_ff;
      b_cols_in  = b_cols_ff;
      if (csr_wr) begin
         case (csr_index)
            REG_OP_MODE: op_mode_in = csr_pwdata[1:0];
            REG_A_ROWS:  a_rows_in  = csr_pwdata[DIM_W-1:0];
            REG_A_COLS:  a_cols_in  = csr_pwdata[DIM_W-1:0];
            REG_B_ROWS:  b_rows_in  = csr_pwdata[DIM_W-1:0];
            REG_B_COLS:  b_cols_in  = csr_pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // Register reads
   always_comb begin
      csr_prdata = '0;
      case (csr_index)
         REG_OP_MODE: csr_prdata = {{(CSR_DW-2){1'b0}}, op_mode_ff};
         REG_A_ROWS:  csr_prdata = {{(CSR_DW-DIM_W){1'b0}}, a_rows_ff};
         REG_A_COLS:  csr_prdata = {{(CSR_DW-DIM_W){1'b0}}, a_cols_ff};
         REG_B_ROWS:  csr_prdata = {{(CSR_DW-DIM_W){1'b0}}, b_rows_ff};
         REG_B_COLS:  csr_prdata = {{(CSR_DW-DIM_W){1'b0}}, b_cols_ff};
         default:     csr_prdata = '0;
      endcase
   end

   // Loads write straight into the operand memories when inside the shape
   assign a_wr_en = req_xfer && (req_cmd == CMD_LOAD_A) &&
                    ({1'b0, req_row} < a_rows_ff) && ({1'b0, req_col} < a_cols_ff);
   assign b_wr_en = req_xfer && (req_cmd == CMD_LOAD_B) &&
                    ({1'b0, req_row} < b_rows_ff) && ({1'b0, req_col} < b_cols_ff);

   // Operand addresses follow the loop counters
   assign a_rd_addr   = (mode_ff == MODE_MULTIPLY) ? {i_ff, k_ff} : {i_ff, j_ff};
   assign b_rd_addr   = (mode_ff == MODE_MULTIPLY) ? {k_ff, j_ff} : {i_ff, j_ff};
   assign res_rd_addr = ld_addr;

   // Shared unit: product, sum or pass-through, then accumulate
   assign mul_low = a_rd_data * b_rd_data;

   always_comb begin
      case (mode_ff)
         MODE_ADD:      term_in = a_rd_data + b_rd_data;
         MODE_MULTIPLY: term_in = mul_low;
         default:       term_in = a_rd_data;
      endcase
   end

   assign acc_sum   = (s2_tag_ff.first ? '0 : acc_ff) + term_ff;
   assign acc_in    = s2_valid_ff ? acc_sum : acc_ff;
   assign res_wr_en = s2_valid_ff && s2_tag_ff.last;

   // Sequencer
   always_comb begin
      logic k_last, j_last, i_last;
      logic a_ok, b_ok, dims_ok;

      state_in        = state_ff;
      result_valid_in = result_valid_ff;
      result_rows_in  = result_rows_ff;
      result_cols_in  = result_cols_ff;
      mode_in         = mode_ff;
      lim_i_in        = lim_i_ff;
      lim_j_in        = lim_j_ff;
      lim_k_in        = lim_k_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      k_in            = k_ff;
      s1_valid_in     = 1'b0;
      s1_tag_in       = s1_tag_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_value_in    = rsp_value_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_rows_in     = rsp_rows_ff;
      rsp_cols_in     = rsp_cols_ff;

      k_last = (({1'b0, k_ff} + 1'b1) == lim_k_ff);
      j_last = (({1'b0, j_ff} + 1'b1) == lim_j_ff);
      i_last = (({1'b0, i_ff} + 1'b1) == lim_i_ff);

      a_ok = (a_rows_ff != '0) && (a_rows_ff <= DIM_W'(MAX_DIM)) &&
             (a_cols_ff != '0) && (a_cols_ff <= DIM_W'(MAX_DIM));
      b_ok = (b_rows_ff != '0) && (b_rows_ff <= DIM_W'(MAX_DIM)) &&
             (b_cols_ff != '0) && (b_cols_ff <= DIM_W'(MAX_DIM));
      case (op_mode_ff)
         MODE_ADD:       dims_ok = a_ok && (a_rows_ff == b_rows_ff) &&
                                   (a_cols_ff == b_cols_ff);
         MODE_MULTIPLY:  dims_ok = a_ok && b_ok && (a_cols_ff == b_rows_ff);
         MODE_TRANSPOSE: dims_ok = a_ok;
         default:        dims_ok = 1'b0;
      endcase

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               rsp_value_in = '0;
               case (req_cmd)
                  CMD_LOAD_A, CMD_LOAD_B: begin
                     // Any load drops the result, even a rejected one
                     result_valid_in = 1'b0;
                     result_rows_in  = '0;
                     result_cols_in  = '0;
                     rsp_valid_in    = 1'b1;
                     rsp_status_in   = (a_wr_en || b_wr_en) ? STATUS_OK : STATUS_ADDR;
                     rsp_rows_in     = '0;
                     rsp_cols_in     = '0;
                  end
                  CMD_COMPUTE: begin
                     result_valid_in = 1'b0;
                     result_rows_in  = '0;
                     result_cols_in  = '0;
                     if (dims_ok) begin
                        mode_in  = op_mode_ff;
                        lim_i_in = a_rows_ff;
                        lim_j_in = (op_mode_ff == MODE_MULTIPLY) ? b_cols_ff : a_cols_ff;
                        lim_k_in = (op_mode_ff == MODE_MULTIPLY) ? a_cols_ff : DIM_W'(1);
                        i_in     = '0;
                        j_in     = '0;
                        k_in     = '0;
                        state_in = ST_RUN;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_DIM;
                        rsp_rows_in   = '0;
                        rsp_cols_in   = '0;
                     end
                  end
                  CMD_READ: begin
                     rsp_rows_in = result_rows_ff;
                     rsp_cols_in = result_cols_ff;
                     if (!result_valid_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_NONE;
                     end else if (({1'b0, req_row} >= result_rows_ff) ||
                                  ({1'b0, req_col} >= result_cols_ff)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_ADDR;
                     end else begin
                        // Result memory latches the address at this edge
                        state_in = ST_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_RUN: begin
            // Issue one element step per cycle
            s1_valid_in     = 1'b1;
            s1_tag_in.first = (k_ff == '0);
            s1_tag_in.last  = k_last;
            s1_tag_in.waddr = (mode_ff == MODE_TRANSPOSE) ? {j_ff, i_ff} : {i_ff, j_ff};
            if (!k_last) begin
               k_in = k_ff + 1'b1;
            end else begin
               k_in = '0;
               if (!j_last) begin
                  j_in = j_ff + 1'b1;
               end else begin
                  j_in = '0;
                  if (!i_last) begin
                     i_in = i_ff + 1'b1;
                  end else begin
                     state_in = ST_DRAIN;
                  end
               end
            end
         end
         ST_DRAIN: begin
            // Finish once the last step has been written back
            if (!s1_valid_ff && !s2_valid_ff) begin
               result_valid_in = 1'b1;
               result_rows_in  = (mode_ff == MODE_TRANSPOSE) ? lim_j_ff : lim_i_ff;
               result_cols_in  = (mode_ff == MODE_TRANSPOSE) ? lim_i_ff : lim_j_ff;
               rsp_valid_in    = 1'b1;
               rsp_value_in    = '0;
               rsp_status_in   = STATUS_OK;
               rsp_rows_in     = result_rows_in;
               rsp_cols_in     = result_cols_in;
               state_in        = ST_IDLE;
            end
         end
         ST_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = res_rd_data;
            rsp_status_in = STATUS_OK;
            state_in      = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         op_mode_ff      <= MODE_MULTIPLY;
         a_rows_ff       <= DIM_W'(1);
         a_cols_ff       <= DIM_W'(1);
         b_rows_ff       <= DIM_W'(1);
         b_cols_ff       <= DIM_W'(1);
         state_ff        <= ST_IDLE;
         result_valid_ff <= 1'b0;
         result_rows_ff  <= '0;
         result_cols_ff  <= '0;
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         op_mode_ff      <= op_mode_in;
         a_rows_ff       <= a_rows_in;
         a_cols_ff       <= a_cols_in;
         b_rows_ff       <= b_rows_in;
         b_cols_ff       <= b_cols_in;
         state_ff        <= state_in;
         result_valid_ff <= result_valid_in;
         result_rows_ff  <= result_rows_in;
         result_cols_ff  <= result_cols_in;
         s1_valid_ff     <= s1_valid_in;
         s2_valid_ff     <= s1_valid_ff;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload and loop state
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      lim_i_ff      <= lim_i_in;
      lim_j_ff      <= lim_j_in;
      lim_k_ff      <= lim_k_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      k_ff          <= k_in;
      s1_tag_ff     <= s1_tag_in;
      s2_tag_ff     <= s1_tag_ff;
      term_ff       <= term_in;
      acc_ff        <= acc_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rows_ff   <= rsp_rows_in;
      rsp_cols_ff   <= rsp_cols_in;
   end

   sme_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_a_ram (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (ld_addr),
      .wr_data (req_value),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   sme_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_b_ram (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (ld_addr),
      .wr_data (req_value),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   sme_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_res_ram (
      .clock   (clock),
      .wr_en   (res_wr_en),
      .wr_addr (s2_tag_ff.waddr),
      .wr_data (acc_sum),
      .rd_addr (res_rd_addr),
      .rd_data (res_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_cols_ff, rsp_rows_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_status_ff;

`ifndef SYNTH
   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (state_ff == ST_IDLE))
      else $error("req_tready high outside idle");

   a_res_write_in_compute: assert property (@(posedge clock) disable iff (reset)
      res_wr_en |-> (state_ff == ST_RUN || state_ff == ST_DRAIN))
      else $error("result memory written outside compute");

   a_pipe_in_compute: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff || s2_valid_ff) |-> (state_ff == ST_RUN || state_ff == ST_DRAIN))
      else $error("pipeline busy outside compute");

   a_compute_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && !s1_valid_ff && !s2_valid_ff)
         |=> (result_valid_ff && rsp_valid_ff && state_ff == ST_IDLE))
      else $error("compute finished without result and response");

   a_load_drops_result: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_cmd == CMD_LOAD_A || req_cmd == CMD_LOAD_B))
         |=> (!result_valid_ff && result_rows_ff == '0 && rsp_valid_ff))
      else $error("load left a result in place");
`endif

endmodule
